/* design/nwc_pkg.sv */
package nwc_pkg;

	// default build
	localparam int unsigned KERNEL_SIZE_DEF = 3;
	localparam int unsigned MAX_WIDTH_DEF   = 1024;

	// field widths
	localparam int unsigned PIX_W     = 8;
	localparam int unsigned COEF_W    = 8;
	localparam int unsigned POS_W     = 10;
	localparam int unsigned SIZE_W    = 11;
	localparam int unsigned VAL_W     = 16;
	localparam int unsigned KROW_W    = 56;
	localparam int unsigned CFG_IDX_W = 3;

	// register map
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE  = 3'd0;
	localparam int unsigned          CFG_KERNEL_ROW0 = 1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd512;

	// result queue, in items
	localparam int unsigned FIFO_DEPTH = 16;

	// position and result flags of one pixel as it moves down the pipe
	typedef struct packed {
		logic             has_filt;
		logic             has_border;
		logic [PIX_W-1:0] pix;
		logic [POS_W-1:0] r;
		logic [POS_W-1:0] c;
	} meta_t;

	// one queued item: up to two results
	typedef struct packed {
		logic signed [VAL_W-1:0] fval;
		meta_t                   meta;
	} entry_t;

endpackage

/* design/nwc_pix_if.sv */
interface nwc_pix_if;
	logic                       valid;
	logic                       ready;
	logic                       start_of_frame;
	logic [nwc_pkg::PIX_W-1:0]  pixel;

	modport source (output valid, output start_of_frame, output pixel, input ready);
	modport sink (input valid, input start_of_frame, input pixel, output ready);
endinterface

/* design/nwc_res_if.sv */
interface nwc_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [nwc_pkg::VAL_W-1:0]  value;
	logic [nwc_pkg::POS_W-1:0]         out_row;
	logic [nwc_pkg::POS_W-1:0]         out_col;
	logic                              is_filtered;
	logic                              last;

	modport source (output valid, output value, output out_row, output out_col,
		output is_filtered, output last, input ready);
	modport sink (input valid, input value, input out_row, input out_col,
		input is_filtered, input last, output ready);
endinterface

/* design/nwc_cfg_if.sv */
interface nwc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [nwc_pkg::CFG_IDX_W-1:0]    index;
	logic [nwc_pkg::KROW_W-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* design/normalized_window_correlation_core.sv */
// KxK normalized window correlation over a square 8-bit image streamed in raster
// order, one pixel per transfer. Each pixel that completes a window (row and column
// both at least K-1) yields the window's sum of pixel times signed coefficient,
// divided by K*K and truncated toward zero, placed at the window centre; each
// pixel within K/2 of an edge is also passed through unchanged at its own
// position. When one pixel yields both, the window result comes first, and the
// last flag marks the final result of a pixel. The input takes one pixel per
// clock while ready is high: a pixel enters, the K-1 line buffers (one RAM, K-1
// pixels wide, indexed by column) are read at its column, and five register
// stages later its results enter a 16-item output queue. A pixel with two results
// is unloaded in two transfers. Input ready drops only while 16 pixels with
// results are in the pipe or the queue, so a waiting result does not block the
// input until the queue fills. The line RAM has no clearing pass: columns not
// yet written in the current frame geometry read as whatever they hold.
// Registers: index 0 is image_size (clamped to [KERNEL_SIZE, MAX_WIDTH]),
// indices 1 to 7 are kernel rows 0 to 6, seven signed bytes each, column 0
// lowest; the config port is always ready and must only be written while the
// block is idle.
module normalized_window_correlation_core #(
	parameter int unsigned KERNEL_SIZE = nwc_pkg::KERNEL_SIZE_DEF,
	parameter int unsigned MAX_WIDTH   = nwc_pkg::MAX_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	nwc_cfg_if.sink    cfg,
	nwc_pix_if.sink    pixels,
	nwc_res_if.source  results
);

	localparam int unsigned HALF_K    = KERNEL_SIZE / 2;
	localparam int unsigned NUM_LINES = KERNEL_SIZE - 1;
	localparam int unsigned KK        = KERNEL_SIZE * KERNEL_SIZE;
	localparam int unsigned ADDR_W    = $clog2(MAX_WIDTH);
	localparam int unsigned LINE_W    = NUM_LINES * nwc_pkg::PIX_W;

	// product of an unsigned pixel and a signed coefficient, plus sum growth
	localparam int unsigned PROD_W = nwc_pkg::PIX_W + nwc_pkg::COEF_W + 1;
	localparam int unsigned ROW_W  = PROD_W + $clog2(KERNEL_SIZE);
	localparam int unsigned TOT_W  = PROD_W + $clog2(KK);

	// divide by K*K: q = (x * M) >> (TOT_W + L), exact for any x below 2^TOT_W
	// with L = clog2(K*K) and M = floor(2^(TOT_W+L) / (K*K)) + 1
	localparam int unsigned DIV_L  = $clog2(KK);
	localparam int unsigned DIV_SH = TOT_W + DIV_L;
	localparam int unsigned MUL_W  = TOT_W + 1;
	localparam int unsigned PRODM_W = TOT_W + MUL_W;
	localparam longint unsigned DIV_MUL_FULL = ((64'd1 << DIV_SH) / KK) + 64'd1;
	localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'(DIV_MUL_FULL);

	localparam int unsigned PEND_W = $clog2(nwc_pkg::FIFO_DEPTH + 1);
	localparam int unsigned FPTR_W = $clog2(nwc_pkg::FIFO_DEPTH) + 1;

	localparam logic [nwc_pkg::SIZE_W-1:0] SIZE_MIN = nwc_pkg::SIZE_W'(KERNEL_SIZE);
	localparam logic [nwc_pkg::SIZE_W-1:0] SIZE_MAX = nwc_pkg::SIZE_W'(MAX_WIDTH);

	//--------------------------------------------------------------------------
	// Configuration registers
	//--------------------------------------------------------------------------
	logic                                 cfg_xfer;
	logic [nwc_pkg::SIZE_W-1:0]           image_size_q;
	logic signed [nwc_pkg::COEF_W-1:0]    coef_q [KERNEL_SIZE][KERNEL_SIZE];

	assign cfg.ready = 1'b1;
	assign cfg_xfer  = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= nwc_pkg::SIZE_RESET;
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				for (int j = 0; j < KERNEL_SIZE; j++) begin
					coef_q[i][j] <= '0;
				end
			end
		end else if (cfg_xfer) begin
			if (cfg.index == nwc_pkg::CFG_IMAGE_SIZE) begin
				image_size_q <= cfg.data[nwc_pkg::SIZE_W-1:0];
			end
			// rows past the kernel size are never read, so they are not kept
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				if (cfg.index == nwc_pkg::CFG_IDX_W'(nwc_pkg::CFG_KERNEL_ROW0 + i)) begin
					for (int j = 0; j < KERNEL_SIZE; j++) begin
						coef_q[i][j] <= cfg.data[j*nwc_pkg::COEF_W +: nwc_pkg::COEF_W];
					end
				end
			end
		end
	end

	//--------------------------------------------------------------------------
	// Position tracking at the input
	//--------------------------------------------------------------------------
	logic                        in_xfer;
	logic [nwc_pkg::SIZE_W-1:0]  size_n;
	logic [nwc_pkg::SIZE_W-1:0]  size_edge;
	logic [nwc_pkg::POS_W-1:0]   row_q, col_q;
	logic [nwc_pkg::POS_W-1:0]   r0, c0, pos_r, pos_c;
	logic [nwc_pkg::SIZE_W-1:0]  r1, c_inc, r_inc;
	logic [nwc_pkg::POS_W-1:0]   row_nx, col_nx;
	logic                        in_filt, in_border;

	assign in_xfer = pixels.valid && pixels.ready;

	always_comb begin
		size_n = image_size_q;
		if (image_size_q < SIZE_MIN) begin
			size_n = SIZE_MIN;
		end else if (image_size_q > SIZE_MAX) begin
			size_n = SIZE_MAX;
		end
	end

	assign size_edge = size_n - nwc_pkg::SIZE_W'(HALF_K);

	always_comb begin
		c0 = pixels.start_of_frame ? '0 : col_q;
		r0 = pixels.start_of_frame ? '0 : row_q;
		// counters can sit past the edge only after the size shrank
		if ({1'b0, c0} >= size_n) begin
			pos_c = '0;
			r1    = {1'b0, r0} + 1'b1;
		end else begin
			pos_c = c0;
			r1    = {1'b0, r0};
		end
		pos_r = (r1 >= size_n) ? '0 : r1[nwc_pkg::POS_W-1:0];

		c_inc = {1'b0, pos_c} + 1'b1;
		r_inc = {1'b0, pos_r} + 1'b1;
		if (c_inc >= size_n) begin
			col_nx = '0;
			row_nx = (r_inc >= size_n) ? '0 : r_inc[nwc_pkg::POS_W-1:0];
		end else begin
			col_nx = c_inc[nwc_pkg::POS_W-1:0];
			row_nx = pos_r;
		end

		in_filt   = (pos_r >= nwc_pkg::POS_W'(KERNEL_SIZE - 1))
			&& (pos_c >= nwc_pkg::POS_W'(KERNEL_SIZE - 1));
		in_border = (pos_r < nwc_pkg::POS_W'(HALF_K)) || (pos_c < nwc_pkg::POS_W'(HALF_K))
			|| ({1'b0, pos_r} >= size_edge) || ({1'b0, pos_c} >= size_edge);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_xfer) begin
			row_q <= row_nx;
			col_q <= col_nx;
		end
	end

	//--------------------------------------------------------------------------
	// Stage 1: line buffer read data, write back of the shifted column
	//--------------------------------------------------------------------------
	logic                  v_s1;
	nwc_pkg::meta_t        meta_s1;
	logic                  fwd_s1;
	logic [LINE_W-1:0]     fwd_data_s1;
	logic [LINE_W-1:0]     line_rdata, line_cur, line_wdata;
	logic [nwc_pkg::PIX_W-1:0] colv [KERNEL_SIZE];

	nwc_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (v_s1),
		.waddr (meta_s1.c[ADDR_W-1:0]),
		.wdata (line_wdata),
		.re    (in_xfer),
		.raddr (pos_c[ADDR_W-1:0]),
		.rdata (line_rdata)
	);

	// a pixel following at the same column (start of frame) would read the
	// RAM in the cycle that column is being written: take the write data
	assign line_cur = fwd_s1 ? fwd_data_s1 : line_rdata;

	always_comb begin
		for (int i = 0; i < NUM_LINES; i++) begin
			colv[i] = line_cur[i*nwc_pkg::PIX_W +: nwc_pkg::PIX_W];
		end
		colv[KERNEL_SIZE-1] = meta_s1.pix;
		for (int i = 0; i < NUM_LINES; i++) begin
			line_wdata[i*nwc_pkg::PIX_W +: nwc_pkg::PIX_W] = colv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= in_xfer;
			fwd_s1 <= in_xfer && v_s1 && (pos_c == meta_s1.c);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			meta_s1.has_filt   <= in_filt;
			meta_s1.has_border <= in_border;
			meta_s1.pix        <= pixels.pixel;
			meta_s1.r          <= pos_r;
			meta_s1.c          <= pos_c;
			fwd_data_s1        <= line_wdata;
		end
	end

	//--------------------------------------------------------------------------
	// Stage 2: window shift
	//--------------------------------------------------------------------------
	logic                      v_s2;
	nwc_pkg::meta_t            meta_s2;
	logic [nwc_pkg::PIX_W-1:0] window_q [KERNEL_SIZE][KERNEL_SIZE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && (meta_s1.has_filt || meta_s1.has_border);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			meta_s2 <= meta_s1;
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				for (int j = 0; j + 1 < KERNEL_SIZE; j++) begin
					window_q[i][j] <= window_q[i][j+1];
				end
				window_q[i][KERNEL_SIZE-1] <= colv[i];
			end
		end
	end

	//--------------------------------------------------------------------------
	// Stage 3: per-row multiply and accumulate
	//--------------------------------------------------------------------------
	logic                     v_s3;
	nwc_pkg::meta_t           meta_s3;
	logic signed [ROW_W-1:0]  rowsum_c  [KERNEL_SIZE];
	logic signed [ROW_W-1:0]  rowsum_s3 [KERNEL_SIZE];

	always_comb begin
		logic signed [PROD_W-1:0] prod;
		logic signed [ROW_W-1:0]  acc;
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			acc = '0;
			for (int j = 0; j < KERNEL_SIZE; j++) begin
				prod = $signed({1'b0, window_q[i][j]}) * coef_q[i][j];
				acc  = acc + ROW_W'(prod);
			end
			rowsum_c[i] = acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			meta_s3   <= meta_s2;
			rowsum_s3 <= rowsum_c;
		end
	end

	//--------------------------------------------------------------------------
	// Stage 4: window total, split into sign and magnitude
	//--------------------------------------------------------------------------
	logic                     v_s4;
	nwc_pkg::meta_t           meta_s4;
	logic signed [TOT_W-1:0]  total_c;
	logic [TOT_W-1:0]         abs_s4;
	logic                     neg_s4;

	always_comb begin
		total_c = '0;
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			total_c = total_c + TOT_W'(rowsum_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			meta_s4 <= meta_s3;
			neg_s4  <= total_c[TOT_W-1];
			abs_s4  <= total_c[TOT_W-1] ? TOT_W'(-total_c) : TOT_W'(total_c);
		end
	end

	//--------------------------------------------------------------------------
	// Stage 5: reciprocal multiply
	//--------------------------------------------------------------------------
	logic                  v_s5;
	nwc_pkg::meta_t        meta_s5;
	logic [PRODM_W-1:0]    prodm_s5;
	logic                  neg_s5;
	logic [nwc_pkg::VAL_W-1:0] quot;
	logic signed [nwc_pkg::VAL_W-1:0] fval;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			meta_s5  <= meta_s4;
			neg_s5   <= neg_s4;
			prodm_s5 <= abs_s4 * DIV_MUL;
		end
	end

	// quotient fits the result range, so its low bits are enough
	assign quot = prodm_s5[DIV_SH +: nwc_pkg::VAL_W];
	assign fval = neg_s5 ? $signed(-quot) : $signed(quot);

	//--------------------------------------------------------------------------
	// Result queue, one entry per pixel with results, unloaded one result per transfer
	//--------------------------------------------------------------------------
	nwc_pkg::entry_t         fifo_q [nwc_pkg::FIFO_DEPTH];
	logic [FPTR_W-1:0]       wp_q, rp_q, fill;
	logic [PEND_W-1:0]       pend_q;
	logic                    sub_q;
	nwc_pkg::entry_t         head;
	logic                    first, res_last, out_xfer, pop, pend_inc;

	assign fill = wp_q - rp_q;
	assign head = fifo_q[rp_q[FPTR_W-2:0]];

	always_ff @(posedge clk) begin
		if (v_s5) begin
			fifo_q[wp_q[FPTR_W-2:0]].fval <= fval;
			fifo_q[wp_q[FPTR_W-2:0]].meta <= meta_s5;
		end
	end

	// window result goes first, then the passthrough of the same pixel
	assign first    = head.meta.has_filt && !sub_q;
	assign res_last = !(first && head.meta.has_border);
	assign out_xfer = results.valid && results.ready;
	assign pop      = out_xfer && res_last;
	assign pend_inc = in_xfer && (in_filt || in_border);

	assign results.valid       = (wp_q != rp_q);
	assign results.value       = first ? head.fval
		: $signed(nwc_pkg::VAL_W'(head.meta.pix));
	assign results.out_row     = first ? head.meta.r - nwc_pkg::POS_W'(HALF_K) : head.meta.r;
	assign results.out_col     = first ? head.meta.c - nwc_pkg::POS_W'(HALF_K) : head.meta.c;
	assign results.is_filtered = first;
	assign results.last        = res_last;

	// pixels with results anywhere between the input and the queue head
	assign pixels.ready = (pend_q < PEND_W'(nwc_pkg::FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			sub_q  <= 1'b0;
			pend_q <= '0;
		end else begin
			if (v_s5) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (out_xfer) begin
				sub_q <= !res_last;
			end
			case ({pend_inc, pop})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	//--------------------------------------------------------------------------
	// Assertions
	//--------------------------------------------------------------------------
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(nwc_pkg::FIFO_DEPTH))
		else $error("pending pixel count beyond queue depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (fill < FPTR_W'(nwc_pkg::FIFO_DEPTH)))
		else $error("result queue written while full");

	a_fill_pend: assert property (@(posedge clk) disable iff (!arst_n)
		PEND_W'(fill) <= pend_q)
		else $error("queued pixels not covered by pending count");

	a_sub_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> (results.valid && head.meta.has_filt && head.meta.has_border))
		else $error("second result phase on a pixel without two results");

	a_fwd_follow: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> (v_s1 && $past(v_s1)))
		else $error("column forward without a preceding write");

endmodule

/* design/nwc_ram.sv */
module nwc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* tb/sv/normalized_window_correlation_core_tb.sv */
`timescale 1ns / 100ps

module normalized_window_correlation_core_tb;

	// build under test: default kernel and line width
	localparam int KS        = nwc_pkg::KERNEL_SIZE_DEF;
	localparam int MW        = nwc_pkg::MAX_WIDTH_DEF;
	localparam int HK        = KS / 2;
	localparam int NUM_KROWS = 7;

	localparam int CLK_HALF = 6;
	// room for the pipe to drain after the last result; leave a wide margin
	localparam int SETTLE_CYCLES = 24;
	// generous wall for the whole run
	localparam int RUN_LIMIT_NS = 20_000_000;

	typedef struct packed {
		logic signed [nwc_pkg::VAL_W-1:0] value;
		logic [nwc_pkg::POS_W-1:0]        row;
		logic [nwc_pkg::POS_W-1:0]        col;
		logic                             filt;
		logic                             last;
	} corr_result_t;

	// Tracks the block's image position, line buffers and window, and keeps
	// the queue of results that the accepted pixels must still produce.
	class corr_board;
		logic [nwc_pkg::SIZE_W-1:0] size_reg;
		logic [nwc_pkg::KROW_W-1:0] krow [NUM_KROWS];
		logic [nwc_pkg::PIX_W-1:0]  lines [KS-1][MW];
		logic [nwc_pkg::PIX_W-1:0]  win [KS][KS];
		int                         row_cnt;
		int                         col_cnt;
		corr_result_t               due[$];
		int                         mismatches;

		function new();
			size_reg = nwc_pkg::SIZE_RESET;
			foreach (krow[i]) krow[i] = '0;
			foreach (lines[i, j]) lines[i][j] = '0;
			foreach (win[i, j]) win[i][j] = '0;
			row_cnt = 0;
			col_cnt = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [nwc_pkg::CFG_IDX_W-1:0] idx,
			logic [nwc_pkg::KROW_W-1:0] data);
			if (idx == nwc_pkg::CFG_IMAGE_SIZE) begin
				size_reg = data[nwc_pkg::SIZE_W-1:0];
			end else begin
				krow[idx - nwc_pkg::CFG_KERNEL_ROW0] = data;
			end
		endfunction

		// image size as the block uses it: clamped to [K, MAX_WIDTH]
		function int eff_size();
			int n;
			n = size_reg;
			if (n < KS) n = KS;
			if (n > MW) n = MW;
			return n;
		endfunction

		function void take_pixel(bit sof, logic [nwc_pkg::PIX_W-1:0] pix);
			int                        n;
			int                        r;
			int                        c;
			int                        acc;
			bit                        has_win;
			bit                        has_edge;
			logic [nwc_pkg::PIX_W-1:0] colv [KS];
			corr_result_t              res;
			n = eff_size();
			if (sof) begin
				row_cnt = 0;
				col_cnt = 0;
			end
			// counters left past the edge by a shrunken size wrap first
			if (col_cnt >= n) begin
				col_cnt = 0;
				row_cnt++;
			end
			if (row_cnt >= n) row_cnt = 0;
			r = row_cnt;
			c = col_cnt;

			// column of K pixels ending at this one; line buffers move up a row
			for (int i = 0; i < KS - 1; i++) colv[i] = lines[i][c];
			colv[KS-1] = pix;
			for (int i = 0; i < KS - 1; i++) lines[i][c] = colv[i+1];
			for (int i = 0; i < KS; i++) begin
				for (int j = 0; j < KS - 1; j++) win[i][j] = win[i][j+1];
				win[i][KS-1] = colv[i];
			end

			has_win  = (r >= KS - 1) && (c >= KS - 1);
			has_edge = (r < HK) || (c < HK) || (r >= n - HK) || (c >= n - HK);

			// window result goes ahead of the border passthrough
			if (has_win) begin
				acc = 0;
				for (int i = 0; i < KS; i++)
					for (int j = 0; j < KS; j++)
						acc += int'(win[i][j]) * int'(signed'(krow[i][8*j +: 8]));
				res.value = nwc_pkg::VAL_W'(acc / (KS * KS));
				res.row   = nwc_pkg::POS_W'(r - HK);
				res.col   = nwc_pkg::POS_W'(c - HK);
				res.filt  = 1'b1;
				res.last  = !has_edge;
				due.push_back(res);
			end
			if (has_edge) begin
				res.value = nwc_pkg::VAL_W'(pix);
				res.row   = nwc_pkg::POS_W'(r);
				res.col   = nwc_pkg::POS_W'(c);
				res.filt  = 1'b0;
				res.last  = 1'b1;
				due.push_back(res);
			end

			if (c + 1 >= n) begin
				col_cnt = 0;
				row_cnt = (r + 1 >= n) ? 0 : r + 1;
			end else begin
				col_cnt = c + 1;
			end
		endfunction

		function void check_result(corr_result_t got);
			corr_result_t want;
			if (due.size() == 0) begin
				$error("unexpected result: value %0d row %0d col %0d",
					got.value, got.row, got.col);
				mismatches++;
				return;
			end
			want = due.pop_front();
			if (got.value !== want.value) begin
				$error("value: expected %0d, got %0d", want.value, got.value);
				mismatches++;
			end
			if (got.row !== want.row) begin
				$error("out_row: expected %0d, got %0d", want.row, got.row);
				mismatches++;
			end
			if (got.col !== want.col) begin
				$error("out_col: expected %0d, got %0d", want.col, got.col);
				mismatches++;
			end
			if (got.filt !== want.filt) begin
				$error("is_filtered: expected %0b, got %0b", want.filt, got.filt);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	nwc_cfg_if cfg_bus ();
	nwc_pix_if pix_bus ();
	nwc_res_if res_bus ();

	normalized_window_correlation_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.pixels  (pix_bus),
		.results (res_bus)
	);

	corr_board board;

	// idle / stall odds in percent, changed per phase
	int src_idle_pct;
	int snk_stall_pct;

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// result side backpressure: a fresh coin at every falling edge
	always @(negedge clk) begin
		res_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// every result transfer is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			board.check_result('{value: res_bus.value, row: res_bus.out_row,
				col: res_bus.out_col, filt: res_bus.is_filtered, last: res_bus.last});
		end
	end

	// hard stop in case the block hangs
	initial begin
		#RUN_LIMIT_NS;
		$display("normalized_window_correlation_core_tb: FAIL");
		$finish;
	end

	// one pixel transfer; random idle cycles go ahead of it
	task automatic send_pixel(bit sof, logic [nwc_pkg::PIX_W-1:0] pix);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_bus.valid <= 1'b0;
			@(negedge clk);
		end
		pix_bus.valid          <= 1'b1;
		pix_bus.start_of_frame <= sof;
		pix_bus.pixel          <= pix;
		do @(posedge clk); while (pix_bus.ready !== 1'b1);
		board.take_pixel(sof, pix);
	endtask

	task automatic pixels_idle();
		@(negedge clk);
		pix_bus.valid <= 1'b0;
	endtask

	task automatic wait_results();
		while (board.due.size() != 0) @(posedge clk);
	endtask

	// block fully quiet: no pixel offered, queue drained, pipe flushed
	task automatic settle();
		pixels_idle();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [nwc_pkg::CFG_IDX_W-1:0] idx,
		logic [nwc_pkg::KROW_W-1:0] data);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic write_size(int size);
		write_reg(nwc_pkg::CFG_IMAGE_SIZE, nwc_pkg::KROW_W'(size));
	endtask

	// same coefficient everywhere, all seven rows written
	task automatic write_kernel_fill(logic [nwc_pkg::COEF_W-1:0] coef);
		for (int i = 0; i < NUM_KROWS; i++)
			write_reg(nwc_pkg::CFG_IDX_W'(nwc_pkg::CFG_KERNEL_ROW0 + i), {7{coef}});
	endtask

	function automatic logic [nwc_pkg::KROW_W-1:0] rand_krow();
		case ($urandom_range(5))
			0: return {7{8'h80}};
			1: return {7{8'h7F}};
			default: return nwc_pkg::KROW_W'({$urandom(), $urandom()});
		endcase
	endfunction

	task automatic write_kernel_random();
		for (int i = 0; i < NUM_KROWS; i++)
			write_reg(nwc_pkg::CFG_IDX_W'(nwc_pkg::CFG_KERNEL_ROW0 + i), rand_krow());
	endtask

	function automatic logic [nwc_pkg::PIX_W-1:0] rand_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return nwc_pkg::PIX_W'($urandom_range(255));
		endcase
	endfunction

	// Random raster stream. Frames start with start_of_frame when asked, then
	// run on through the counter wrap; a stray start_of_frame now and then
	// restarts the frame mid-way. Halfway through, the sender holds off until
	// every outstanding result is back.
	task automatic stream_pixels(int count, bit open_with_sof);
		bit sof;
		for (int k = 0; k < count; k++) begin
			sof = (k == 0 && open_with_sof) || ($urandom_range(99) < 2);
			send_pixel(sof, rand_pixel());
			if (k == count / 2) begin
				pixels_idle();
				wait_results();
			end
		end
	endtask

	initial begin
		board = new();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		arst_n = 1'b0;
		pix_bus.valid          = 1'b0;
		pix_bus.start_of_frame = 1'b0;
		pix_bus.pixel          = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed ---
		// size 0 clamps up to K: a 3x3 image, one window plus eight borders.
		// Every coefficient -128 and every pixel 255 gives the lowest average;
		// the corner pixel yields the window result and then its own border.
		write_size(0);
		write_kernel_fill(8'h80);
		for (int k = 0; k < 9; k++) send_pixel(k == 0, 8'hFF);
		settle();

		// all +127: highest average; no start_of_frame, counters wrap on their own
		write_kernel_fill(8'h7F);
		for (int k = 0; k < 9; k++) send_pixel(1'b0, 8'hFF);
		settle();

		// mixed bit patterns, centre pixel with no result, then a restart mid-frame
		write_kernel_random();
		send_pixel(1'b0, 8'h55);
		send_pixel(1'b0, 8'hAA);
		send_pixel(1'b0, 8'h00);
		send_pixel(1'b0, 8'h55);
		send_pixel(1'b0, 8'hAA);
		send_pixel(1'b1, 8'h00);
		send_pixel(1'b0, 8'hFF);
		send_pixel(1'b0, 8'h5A);
		settle();

		// --- widest image ---
		// 2047 clamps to MAX_WIDTH; stream more pixels than one row holds (stray
		// start_of_frame pixels may restart the frame on the way), then shrink while
		// the counters sit past the new edge and keep streaming without an opening restart.
		write_size(2047);
		write_kernel_random();
		stream_pixels(MW + 60, 1'b1);
		settle();
		write_size(6);
		src_idle_pct  = 16;
		snk_stall_pct = 16;
		stream_pixels(200, 1'b0);
		settle();

		// --- random phases, one per idle profile ---
		// sizes grow only with a start_of_frame on the next pixel, so no window
		// ever reaches line buffer columns this frame has not written
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		write_size($urandom_range(4, 16));
		write_kernel_random();
		stream_pixels(170, 1'b1);
		settle();

		src_idle_pct  = 87;
		snk_stall_pct = 0;
		write_size(3);
		write_kernel_random();
		stream_pixels(170, 1'b1);
		settle();

		src_idle_pct  = 0;
		snk_stall_pct = 87;
		write_size($urandom_range(4, 16));
		write_kernel_random();
		stream_pixels(170, 1'b1);
		settle();

		src_idle_pct  = 16;
		snk_stall_pct = 16;
		write_size($urandom_range(4, 16));
		write_kernel_random();
		stream_pixels(170, 1'b1);
		settle();

		if (board.mismatches == 0) begin
			$display("normalized_window_correlation_core_tb: PASS");
		end else begin
			$display("normalized_window_correlation_core_tb: FAIL");
		end
		$finish;
	end

endmodule
